### rtl/zcd_pkg.sv
`timescale 1ns / 1ps

package zcd_pkg;

   // central directory record layout
   localparam logic [31:0] CD_SIGNATURE = 32'h0201_4b50;
   localparam logic [31:0] SIZE_ESCAPE  = 32'hffff_ffff;
   localparam logic [15:0] ZIP64_TAG    = 16'h0001;
   localparam int          UTF8_BIT     = 11;
   localparam logic [16:0] HEADER_BYTES = 17'd46;

   localparam logic [15:0] OFS_FLAGS    = 16'd8;
   localparam logic [15:0] OFS_TIME     = 16'd12;
   localparam logic [15:0] OFS_DATE     = 16'd14;
   localparam logic [15:0] OFS_SIZE     = 16'd24;
   localparam logic [15:0] OFS_NAME_LEN = 16'd28;
   localparam logic [15:0] OFS_XTRA_LEN = 16'd30;
   localparam logic [15:0] OFS_CMNT_LEN = 16'd32;
   localparam logic [15:0] SIG_BYTES    = 16'd4;

   // name bytes passed out per record
   localparam logic [15:0] NAME_LIMIT   = 16'd255;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_NAME    = 2'd1,
      PH_EXTRA   = 2'd2,
      PH_COMMENT = 2'd3
   } phase_type;

   typedef struct packed {
      logic      found;
      phase_type phase;
   } section_type;

   typedef struct packed {
      logic        name_valid;
      logic [7:0]  name_char;
      logic        record_done;
      logic        bad_signature;
      logic        utf8_name;
      logic [15:0] mod_time;
      logic [15:0] mod_date;
      logic [63:0] entry_size;
      logic        last_entry;
   } rsp_type;

   // first non-empty section at or after from
   function automatic section_type open_next(input phase_type from,
                                             input logic [15:0] name_len,
                                             input logic [15:0] extra_len,
                                             input logic [15:0] comment_len);
      section_type s;
      s.found = 1'b1;
      s.phase = PH_HEADER;
      if ((from == PH_NAME) && (name_len != 16'd0)) begin
         s.phase = PH_NAME;
      end else if ((from != PH_COMMENT) && (extra_len != 16'd0)) begin
         s.phase = PH_EXTRA;
      end else if (comment_len != 16'd0) begin
         s.phase = PH_COMMENT;
      end else begin
         s.found = 1'b0;
      end
      return s;
   endfunction

endpackage

### rtl/zcd_core.sv
`timescale 1ns / 1ps

module zcd_core import zcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  data_byte,
   input  logic        csr_write_enable,
   input  logic [63:0] csr_write_data,
   output logic        res_valid,
   output rsp_type     res
);

   phase_type   phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [63:0] left_ff, left_in;
   logic [15:0] flags_ff, flags_in;
   logic [15:0] time_ff, time_in;
   logic [15:0] date_ff, date_in;
   logic [31:0] size_lo_ff, size_lo_in;
   logic [15:0] name_len_ff, name_len_in;
   logic [15:0] extra_len_ff, extra_len_in;
   logic [15:0] comment_len_ff, comment_len_in;
   logic [63:0] resolved_ff, resolved_in;
   logic [15:0] tag_ff, tag_in;
   logic [15:0] item_len_ff, item_len_in;
   logic [15:0] item_off_ff, item_off_in;
   logic        walk_done_ff, walk_done_in;
   logic        halted_ff, halted_in;

   logic        name_out;
   logic        done;
   logic        bad;
   logic [16:0] p1;
   logic [15:0] new_len;
   logic [15:0] d;
   logic        zip64_item;
   section_type sect;

   always_comb begin
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      left_in        = left_ff;
      flags_in       = flags_ff;
      time_in        = time_ff;
      date_in        = date_ff;
      size_lo_in     = size_lo_ff;
      name_len_in    = name_len_ff;
      extra_len_in   = extra_len_ff;
      comment_len_in = comment_len_ff;
      resolved_in    = resolved_ff;
      tag_in         = tag_ff;
      item_len_in    = item_len_ff;
      item_off_in    = item_off_ff;
      walk_done_in   = walk_done_ff;
      halted_in      = halted_ff;
      name_out       = 1'b0;
      done           = 1'b0;
      bad            = 1'b0;
      p1             = {1'b0, pos_ff} + 17'd1;
      new_len        = {data_byte, item_len_ff[7:0]};
      d              = item_off_ff - 16'd4;
      zip64_item     = (tag_ff == ZIP64_TAG) && (item_len_ff >= 16'd8);
      sect           = '0;

      if (step && !halted_ff) begin
         case (phase_ff)
            PH_HEADER: begin
               if ((pos_ff == 16'd0) && (left_ff == 64'd0)) begin
                  // nothing left to parse
               end else if ((pos_ff < SIG_BYTES) &&
                            (data_byte != CD_SIGNATURE[{pos_ff[1:0], 3'b000} +: 8])) begin
                  halted_in = 1'b1;
                  bad       = 1'b1;
               end else begin
                  case (pos_ff)
                     OFS_FLAGS:            flags_in[7:0]        = data_byte;
                     OFS_FLAGS + 16'd1:    flags_in[15:8]       = data_byte;
                     OFS_TIME:             time_in[7:0]         = data_byte;
                     OFS_TIME + 16'd1:     time_in[15:8]        = data_byte;
                     OFS_DATE:             date_in[7:0]         = data_byte;
                     OFS_DATE + 16'd1:     date_in[15:8]        = data_byte;
                     OFS_SIZE:             size_lo_in[7:0]      = data_byte;
                     OFS_SIZE + 16'd1:     size_lo_in[15:8]     = data_byte;
                     OFS_SIZE + 16'd2:     size_lo_in[23:16]    = data_byte;
                     OFS_SIZE + 16'd3:     size_lo_in[31:24]    = data_byte;
                     OFS_NAME_LEN:         name_len_in[7:0]     = data_byte;
                     OFS_NAME_LEN + 16'd1: name_len_in[15:8]    = data_byte;
                     OFS_XTRA_LEN:         extra_len_in[7:0]    = data_byte;
                     OFS_XTRA_LEN + 16'd1: extra_len_in[15:8]   = data_byte;
                     OFS_CMNT_LEN:         comment_len_in[7:0]  = data_byte;
                     OFS_CMNT_LEN + 16'd1: comment_len_in[15:8] = data_byte;
                     default: ;
                  endcase
                  if (p1 >= HEADER_BYTES) begin
                     resolved_in  = {32'd0, size_lo_ff};
                     walk_done_in = (size_lo_ff != SIZE_ESCAPE);
                     item_off_in  = '0;
                     tag_in       = '0;
                     item_len_in  = '0;
                     sect = open_next(PH_NAME, name_len_ff, extra_len_ff, comment_len_ff);
                     if (sect.found) begin
                        phase_in = sect.phase;
                        pos_in   = '0;
                     end else begin
                        done = 1'b1;
                     end
                  end else begin
                     pos_in = p1[15:0];
                  end
               end
            end
            PH_NAME: begin
               name_out = (pos_ff < NAME_LIMIT);
               if (p1 >= {1'b0, name_len_ff}) begin
                  sect = open_next(PH_EXTRA, name_len_ff, extra_len_ff, comment_len_ff);
                  if (sect.found) begin
                     phase_in = sect.phase;
                     pos_in   = '0;
                  end else begin
                     done = 1'b1;
                  end
               end else begin
                  pos_in = p1[15:0];
               end
            end
            PH_EXTRA: begin
               // tag-length walk, only while looking for the 64-bit size
               if (!walk_done_ff) begin
                  if ((item_off_ff == 16'd0) &&
                      (({2'b00, pos_ff} + 18'd4) > {2'b00, extra_len_ff})) begin
                     walk_done_in = 1'b1;
                  end else if (item_off_ff < 16'd2) begin
                     if (item_off_ff[0]) tag_in[15:8] = data_byte;
                     else                tag_in[7:0]  = data_byte;
                     item_off_in = item_off_ff + 16'd1;
                  end else if (item_off_ff < 16'd4) begin
                     if (item_off_ff[0]) begin
                        item_len_in[15:8] = data_byte;
                        if (({2'b00, pos_ff} + 18'd1 + {2'b00, new_len}) >
                            {2'b00, extra_len_ff}) begin
                           walk_done_in = 1'b1;
                        end else if (new_len == 16'd0) begin
                           item_off_in = '0;
                        end else begin
                           item_off_in = item_off_ff + 16'd1;
                        end
                     end else begin
                        item_len_in[7:0] = data_byte;
                        item_off_in      = item_off_ff + 16'd1;
                     end
                  end else if (zip64_item) begin
                     resolved_in[{d[2:0], 3'b000} +: 8] = data_byte;
                     if (d >= 16'd7) walk_done_in = 1'b1;
                     else            item_off_in  = item_off_ff + 16'd1;
                  end else if (({1'b0, d} + 17'd1) >= {1'b0, item_len_ff}) begin
                     item_off_in = '0;
                  end else begin
                     item_off_in = item_off_ff + 16'd1;
                  end
               end
               if (p1 >= {1'b0, extra_len_ff}) begin
                  sect = open_next(PH_COMMENT, name_len_ff, extra_len_ff, comment_len_ff);
                  if (sect.found) begin
                     phase_in = sect.phase;
                     pos_in   = '0;
                  end else begin
                     done = 1'b1;
                  end
               end else begin
                  pos_in = p1[15:0];
               end
            end
            PH_COMMENT: begin
               if (p1 >= {1'b0, comment_len_ff}) done = 1'b1;
               else                              pos_in = p1[15:0];
            end
            default: begin
               phase_in = PH_HEADER;
               pos_in   = '0;
            end
         endcase

         if (done) begin
            left_in  = (left_ff != 64'd0) ? (left_ff - 64'd1) : left_ff;
            phase_in = PH_HEADER;
            pos_in   = '0;
         end
      end

      // a register write restarts at a record boundary
      if (csr_write_enable) begin
         left_in  = csr_write_data;
         phase_in = PH_HEADER;
         pos_in   = '0;
      end

      res_valid         = name_out || done || bad;
      res               = '0;
      res.name_valid    = name_out;
      res.name_char     = name_out ? data_byte : 8'd0;
      res.record_done   = done;
      res.bad_signature = bad;
      res.utf8_name     = (name_out || done) && flags_ff[UTF8_BIT];
      if (done) begin
         res.mod_time   = time_ff;
         res.mod_date   = date_ff;
         res.entry_size = resolved_in;
         res.last_entry = (left_ff == 64'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         pos_ff         <= '0;
         left_ff        <= '0;
         flags_ff       <= '0;
         time_ff        <= '0;
         date_ff        <= '0;
         size_lo_ff     <= '0;
         name_len_ff    <= '0;
         extra_len_ff   <= '0;
         comment_len_ff <= '0;
         resolved_ff    <= '0;
         tag_ff         <= '0;
         item_len_ff    <= '0;
         item_off_ff    <= '0;
         walk_done_ff   <= 1'b0;
         halted_ff      <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         left_ff        <= left_in;
         flags_ff       <= flags_in;
         time_ff        <= time_in;
         date_ff        <= date_in;
         size_lo_ff     <= size_lo_in;
         name_len_ff    <= name_len_in;
         extra_len_ff   <= extra_len_in;
         comment_len_ff <= comment_len_in;
         resolved_ff    <= resolved_in;
         tag_ff         <= tag_in;
         item_len_ff    <= item_len_in;
         item_off_ff    <= item_off_in;
         walk_done_ff   <= walk_done_in;
         halted_ff      <= halted_in;
      end
   end

endmodule

### rtl/zcd_out_buf.sv
`timescale 1ns / 1ps

module zcd_out_buf import zcd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_res,
   output logic    full,
   output logic    out_valid,
   output rsp_type out_res,
   input  logic    out_stall
);

   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   logic    take;

   always_comb begin
      take          = main_valid_ff && !out_stall;
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // input is held off while the skid word waits
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || take) begin
            main_in       = in_res;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_res;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_res   = main_ff;

endmodule

### rtl/zip_central_directory_parser.sv
`timescale 1ns / 1ps

// channel   ports                                  word
// -------   ------------------------------------   -----------------------------------
// req       req_valid, req_stall, req_data_byte    one byte of the central directory
// rsp       rsp_valid, rsp_stall, rsp_*            name byte, record end or error
// csr       csr_write_enable, csr_write_data       entry count, loaded at once
//
// one byte is taken per cycle while req_stall is low; its result (if any) is
// registered into the output register, or into the skid word while that one waits
// a two-word output buffer keeps taking bytes while a result waits, req_stall
// rises only when both words are full and is driven from a flop
// reset is synchronous, active high; it clears the entry count and any halt
// a bad signature halts all parsing until reset

module zip_central_directory_parser import zcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_name_valid,
   output logic [7:0]  rsp_name_char,
   output logic        rsp_record_done,
   output logic        rsp_bad_signature,
   output logic        rsp_utf8_name,
   output logic [15:0] rsp_mod_time,
   output logic [15:0] rsp_mod_date,
   output logic [63:0] rsp_entry_size,
   output logic        rsp_last_entry,

   input  logic        csr_write_enable,
   input  logic [63:0] csr_write_data
);

   logic    step;
   logic    core_valid;
   rsp_type core_res;
   rsp_type out_res;

   // byte accepted this edge
   assign step = req_valid && !req_stall;

   // per-byte parse: header capture, name pass-through, extra walk, comment skip
   zcd_core u_core (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .data_byte        (req_data_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .res_valid        (core_valid),
      .res              (core_res)
   );

   // result register plus skid word
   zcd_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (core_valid),
      .in_res    (core_res),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_res   (out_res),
      .out_stall (rsp_stall)
   );

   assign rsp_name_valid    = out_res.name_valid;
   assign rsp_name_char     = out_res.name_char;
   assign rsp_record_done   = out_res.record_done;
   assign rsp_bad_signature = out_res.bad_signature;
   assign rsp_utf8_name     = out_res.utf8_name;
   assign rsp_mod_time      = out_res.mod_time;
   assign rsp_mod_date      = out_res.mod_date;
   assign rsp_entry_size    = out_res.entry_size;
   assign rsp_last_entry    = out_res.last_entry;

`ifndef ASSERT_OFF
   // skid word is only used behind a waiting output word
   a_stall_needs_rsp : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output register");

   // an error word carries nothing else
   a_bad_alone : assert property (@(posedge clock) disable iff (reset)
      core_valid && core_res.bad_signature |->
         !core_res.name_valid && !core_res.record_done)
      else $error("error word mixed with name or record end");

   // after an error the parser stays silent
   a_halt_silent : assert property (@(posedge clock) disable iff (reset)
      core_valid && core_res.bad_signature |=> !core_valid)
      else $error("result produced after bad signature");

   // buffer fills only while the output is held
   a_stall_rise : assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_stall))
      else $error("skid word filled without output stall");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import zcd_pkg::*;

   // cycles with no word moving on either channel before the run is given up
   localparam int WATCHDOG_LIMIT = 2000;
   // cycles a byte without a result may still spend inside the parser
   localparam int DRAIN_CYCLES   = 4;

   logic        clock;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_name_valid;
   logic [7:0]  rsp_name_char;
   logic        rsp_record_done;
   logic        rsp_bad_signature;
   logic        rsp_utf8_name;
   logic [15:0] rsp_mod_time;
   logic [15:0] rsp_mod_date;
   logic [63:0] rsp_entry_size;
   logic        rsp_last_entry;

   logic        csr_write_enable = 1'b0;
   logic [63:0] csr_write_data = 64'h0;

   zip_central_directory_parser uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_name_valid    (rsp_name_valid),
      .rsp_name_char     (rsp_name_char),
      .rsp_record_done   (rsp_record_done),
      .rsp_bad_signature (rsp_bad_signature),
      .rsp_utf8_name     (rsp_utf8_name),
      .rsp_mod_time      (rsp_mod_time),
      .rsp_mod_date      (rsp_mod_date),
      .rsp_entry_size    (rsp_entry_size),
      .rsp_last_entry    (rsp_last_entry),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // stream bookkeeping
   // ------------------------------------------------------------------

   logic [7:0] cd_stream [$];        // bytes waiting to be sent, head is on the bus
   rsp_type    awaited_results [$];  // results the parser still owes us
   logic [7:0] extra_buf [$];        // extra field of the record being built
   int         stim_bytes = 0;
   int         errors = 0;
   int         idle_pct = 20;        // chance of starting an idle burst, per word
   bit         quiet = 1'b0;         // no idling at all once set
   int         gap_left = 0;
   int         stall_left = 0;
   int         idle_cycles = 0;

   // ------------------------------------------------------------------
   // parser shadow state, mirrors what the block should hold
   // ------------------------------------------------------------------

   phase_type   cur_section = PH_HEADER;
   int          sect_pos = 0;          // byte offset inside header or section
   logic [63:0] records_remaining = 64'h0;
   logic [15:0] gp_flags = 16'h0;
   logic [15:0] dos_time = 16'h0;
   logic [15:0] dos_date = 16'h0;
   logic [31:0] size32 = 32'h0;
   logic [15:0] name_len = 16'h0;
   logic [15:0] extra_len = 16'h0;
   logic [15:0] comment_len = 16'h0;
   logic [63:0] size_out = 64'h0;     // 32-bit size, or the zip64 size once found
   logic [15:0] xitem_tag = 16'h0;
   logic [15:0] xitem_len = 16'h0;
   int          xitem_ofs = 0;        // offset inside the current extra item
   bit          xwalk_stopped = 1'b0;
   bit          parser_halted = 1'b0;

   // jump to the first non-empty section at or after first
   function automatic bit open_section_from(input phase_type first);
      int s;
      logic [15:0] len;
      for (s = first; s <= PH_COMMENT; s++) begin
         len = (s == PH_NAME) ? name_len : (s == PH_EXTRA) ? extra_len : comment_len;
         if (len != 16'd0) begin
            cur_section = phase_type'(s);
            sect_pos = 0;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // advance the shadow parser by one accepted byte and queue its result
   task automatic parse_cd_byte(input logic [7:0] b);
      int      p;
      int      d;
      bit      done;
      rsp_type r;
      p = sect_pos;
      done = 1'b0;
      r = '0;
      // halted parser, or nothing left to count: the byte just vanishes
      if (parser_halted || (cur_section == PH_HEADER && p == 0 && records_remaining == 0))
         return;
      case (cur_section)
         PH_HEADER: begin
            if (p < SIG_BYTES && b != CD_SIGNATURE[8*p +: 8]) begin
               parser_halted = 1'b1;
               r.bad_signature = 1'b1;
               awaited_results.push_back(r);
               return;
            end
            // little-endian field capture
            if (p == OFS_FLAGS || p == OFS_FLAGS + 1)
               gp_flags[8*(p - OFS_FLAGS) +: 8] = b;
            else if (p == OFS_TIME || p == OFS_TIME + 1)
               dos_time[8*(p - OFS_TIME) +: 8] = b;
            else if (p == OFS_DATE || p == OFS_DATE + 1)
               dos_date[8*(p - OFS_DATE) +: 8] = b;
            else if (p >= OFS_SIZE && p <= OFS_SIZE + 3)
               size32[8*(p - OFS_SIZE) +: 8] = b;
            else if (p == OFS_NAME_LEN || p == OFS_NAME_LEN + 1)
               name_len[8*(p - OFS_NAME_LEN) +: 8] = b;
            else if (p == OFS_XTRA_LEN || p == OFS_XTRA_LEN + 1)
               extra_len[8*(p - OFS_XTRA_LEN) +: 8] = b;
            else if (p == OFS_CMNT_LEN || p == OFS_CMNT_LEN + 1)
               comment_len[8*(p - OFS_CMNT_LEN) +: 8] = b;
            if (p + 1 >= HEADER_BYTES) begin
               size_out = {32'h0, size32};
               // the extra field only matters when the 32-bit size is escaped
               xwalk_stopped = (size32 != SIZE_ESCAPE);
               xitem_ofs = 0;
               xitem_tag = 16'h0;
               xitem_len = 16'h0;
               if (!open_section_from(PH_NAME)) done = 1'b1;
            end else begin
               sect_pos = p + 1;
            end
         end
         PH_NAME: begin
            if (p < NAME_LIMIT) begin
               r.name_valid = 1'b1;
               r.name_char = b;
            end
            if (p + 1 >= name_len) begin
               if (!open_section_from(PH_EXTRA)) done = 1'b1;
            end else begin
               sect_pos = p + 1;
            end
         end
         PH_EXTRA: begin
            // tag-length walk looking for the zip64 item
            if (!xwalk_stopped) begin
               if (xitem_ofs == 0 && p + 4 > extra_len) begin
                  xwalk_stopped = 1'b1;
               end else if (xitem_ofs < 2) begin
                  xitem_tag[8*xitem_ofs +: 8] = b;
                  xitem_ofs++;
               end else if (xitem_ofs < 4) begin
                  xitem_len[8*(xitem_ofs - 2) +: 8] = b;
                  if (xitem_ofs == 3 && p + 1 + xitem_len > extra_len)
                     xwalk_stopped = 1'b1;
                  else if (xitem_ofs == 3 && xitem_len == 16'd0)
                     xitem_ofs = 0;
                  else
                     xitem_ofs++;
               end else begin
                  d = xitem_ofs - 4;
                  if (xitem_tag == ZIP64_TAG && xitem_len >= 16'd8) begin
                     size_out[8*d +: 8] = b;
                     if (d >= 7) xwalk_stopped = 1'b1;
                     else xitem_ofs++;
                  end else if (d + 1 >= xitem_len) begin
                     xitem_ofs = 0;
                  end else begin
                     xitem_ofs++;
                  end
               end
            end
            if (p + 1 >= extra_len) begin
               if (!open_section_from(PH_COMMENT)) done = 1'b1;
            end else begin
               sect_pos = p + 1;
            end
         end
         default: begin
            if (p + 1 >= comment_len) done = 1'b1;
            else sect_pos = p + 1;
         end
      endcase
      if (r.name_valid || done) r.utf8_name = gp_flags[UTF8_BIT];
      if (done) begin
         r.record_done = 1'b1;
         r.mod_time = dos_time;
         r.mod_date = dos_date;
         r.entry_size = size_out;
         r.last_entry = (records_remaining == 64'd1);
         if (records_remaining != 64'd0) records_remaining--;
         cur_section = PH_HEADER;
         sect_pos = 0;
      end
      if (r.name_valid || done) awaited_results.push_back(r);
   endtask

   // ------------------------------------------------------------------
   // driver: presents cd_stream one word at a time, random idle bursts
   // ------------------------------------------------------------------

   always @(posedge clock) begin : drive
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            parse_cd_byte(req_data_byte);
            void'(cd_stream.pop_front());
            next_valid = 1'b0;
         end
         // a word only changes once it has been taken
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cd_stream.size() != 0) begin
               if (!quiet && $urandom_range(99) < idle_pct) begin
                  gap_left = $urandom_range(7);
               end else begin
                  next_valid = 1'b1;
                  req_data_byte <= cd_stream[0];
               end
            end
         end
         req_valid <= next_valid;
      end
   end

   // ------------------------------------------------------------------
   // monitor: random stall bursts, compares each result field by field
   // ------------------------------------------------------------------

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      logic    next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error({"result word with nothing outstanding: name_valid %0b ",
                       "record_done %0b bad_signature %0b"},
                      rsp_name_valid, rsp_record_done, rsp_bad_signature);
               errors++;
            end else begin
               want = awaited_results.pop_front();
               check_field("name_valid", want.name_valid, rsp_name_valid);
               check_field("name_char", want.name_char, rsp_name_char);
               check_field("record_done", want.record_done, rsp_record_done);
               check_field("bad_signature", want.bad_signature, rsp_bad_signature);
               check_field("utf8_name", want.utf8_name, rsp_utf8_name);
               check_field("mod_time", want.mod_time, rsp_mod_time);
               check_field("mod_date", want.mod_date, rsp_mod_date);
               check_field("entry_size", want.entry_size, rsp_entry_size);
               check_field("last_entry", want.last_entry, rsp_last_entry);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            next_stall = 1'b1;
         end else if (!quiet && $urandom_range(99) < idle_pct) begin
            stall_left = $urandom_range(7);
            next_stall = 1'b1;
         end else begin
            next_stall = 1'b0;
         end
         rsp_stall <= next_stall;
      end
   end

   // watchdog: ends the run if no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // stimulus builders
   // ------------------------------------------------------------------

   task automatic add_junk(input int n);
      repeat (n) extra_buf.push_back(8'($urandom));
   endtask

   // one extra item header plus data_bytes of payload (may be short of len)
   task automatic add_item(input logic [15:0] tag, input int len, input int data_bytes);
      logic [15:0] l;
      l = 16'(len);
      extra_buf.push_back(tag[7:0]);
      extra_buf.push_back(tag[15:8]);
      extra_buf.push_back(l[7:0]);
      extra_buf.push_back(l[15:8]);
      add_junk(data_bytes);
   endtask

   // queues a record with extra_buf as its extra field; cut < 0 sends it whole,
   // otherwise only the first cut bytes
   task automatic push_record(input int nlen, input int clen, input logic [15:0] flags,
                              input logic [31:0] size_field, input int cut);
      logic [7:0]  rec [$];
      logic [15:0] nl;
      logic [15:0] xl;
      logic [15:0] cl;
      int          i;
      nl = 16'(nlen);
      xl = 16'(extra_buf.size());
      cl = 16'(clen);
      for (i = 0; i < HEADER_BYTES; i++) rec.push_back(8'($urandom));
      for (i = 0; i < SIG_BYTES; i++) rec[i] = CD_SIGNATURE[8*i +: 8];
      rec[OFS_FLAGS]        = flags[7:0];
      rec[OFS_FLAGS + 1]    = flags[15:8];
      for (i = 0; i < 4; i++) rec[OFS_SIZE + i] = size_field[8*i +: 8];
      rec[OFS_NAME_LEN]     = nl[7:0];
      rec[OFS_NAME_LEN + 1] = nl[15:8];
      rec[OFS_XTRA_LEN]     = xl[7:0];
      rec[OFS_XTRA_LEN + 1] = xl[15:8];
      rec[OFS_CMNT_LEN]     = cl[7:0];
      rec[OFS_CMNT_LEN + 1] = cl[15:8];
      repeat (nlen) rec.push_back(8'($urandom));
      foreach (extra_buf[k]) rec.push_back(extra_buf[k]);
      repeat (clen) rec.push_back(8'($urandom));
      for (i = 0; i < rec.size() && (cut < 0 || i < cut); i++) begin
         cd_stream.push_back(rec[i]);
         stim_bytes++;
      end
      extra_buf.delete();
   endtask

   // well-formed record with random content and a random extra field layout
   task automatic random_record(input int cut);
      logic [31:0] size_field;
      int          nlen;
      int          clen;
      int          x;
      extra_buf.delete();
      size_field = ($urandom_range(4) < 3) ? SIZE_ESCAPE : $urandom;
      nlen = ($urandom_range(19) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 10);
      clen = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0;
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(5))
            0, 1: begin
               x = $urandom_range(8, 28);
               add_item(ZIP64_TAG, x, x);
            end
            2: begin
               x = $urandom_range(0, 7);
               add_item(ZIP64_TAG, x, x);
            end
            3: begin
               x = $urandom_range(0, 12);
               add_item(16'($urandom), x, x);
            end
            default: add_item(16'($urandom), 0, 0);
         endcase
      end
      // ragged tails: short item header, item running past the end, loose noise
      case ($urandom_range(7))
         0: add_junk($urandom_range(1, 3));
         1: begin
            x = $urandom_range(0, 6);
            add_item(($urandom_range(1) == 0) ? ZIP64_TAG : 16'($urandom),
                     x + $urandom_range(1, 20), x);
         end
         2: add_junk($urandom_range(0, 40));
         default: ;
      endcase
      push_record(nlen, clen, 16'($urandom), size_field, cut);
   endtask

   task automatic write_entry_count(input logic [63:0] count);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      // shadow copy follows the write; parser restarts at a header boundary
      records_remaining = count;
      cur_section = PH_HEADER;
      sect_pos = 0;
   endtask

   // sender holds off until every word is taken and every result is back
   task automatic wait_idle();
      while (cd_stream.size() != 0 || awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------

   initial begin : stimulus
      int          records;
      int          stop_at;
      int          x;
      logic [63:0] count;
      logic [7:0]  wrong;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // entry count still zero from reset: everything is dropped
      repeat (6) begin
         cd_stream.push_back(8'($urandom));
         stim_bytes++;
      end
      wait_idle();

      write_entry_count(64'd3);
      // empty record, ends on the last header byte
      push_record(0, 0, 16'hffff, 32'h0000_0000, -1);
      // escaped size resolved by a zip64 item
      add_item(ZIP64_TAG, 8, 8);
      push_record(1, 1, 16'h0000, SIZE_ESCAPE, -1);
      // escaped size, no usable zip64 item: all-ones size stands
      add_item(16'h5455, 5, 5);
      add_item(ZIP64_TAG, 4, 4);
      add_item(16'hffff, 0, 0);
      push_record(NAME_LIMIT, 0, 16'h0800, SIZE_ESCAPE, -1);
      // count used up, trailing bytes are dropped
      repeat (5) begin
         cd_stream.push_back(8'($urandom));
         stim_bytes++;
      end
      wait_idle();

      write_entry_count(64'hffff_ffff_ffff_ffff);
      // name past the limit, the last unreported name byte ends the record
      push_record(NAME_LIMIT + 1, 0, 16'h0800, 32'h1234_5678, -1);
      // too few bytes left for an item header
      add_junk(3);
      push_record(2, 0, 16'h0000, SIZE_ESCAPE, -1);
      // item length runs past the extra field
      add_item(16'h000a, 4, 4);
      add_item(ZIP64_TAG, 20, 6);
      push_record(0, 2, 16'hf7ff, SIZE_ESCAPE, -1);
      // zip64 item after a zero-length item, long zip64 payload
      add_item(16'h1234, 0, 0);
      add_item(ZIP64_TAG, 28, 28);
      push_record(3, 3, 16'h0800, SIZE_ESCAPE, -1);
      // size not escaped, zip64 item has to be ignored
      add_item(ZIP64_TAG, 8, 8);
      push_record(1, 0, 16'h0000, 32'hffff_fffe, -1);
      // record cut short, the next write drops it
      random_record(20);
      wait_idle();

      // random phases of well-formed records, some with a partial record at the end
      stop_at = stim_bytes + 200;
      while (stim_bytes < stop_at) begin
         case ($urandom_range(2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 50;
         endcase
         records = $urandom_range(1, 12);
         count = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'(records);
         write_entry_count(count);
         repeat (records) random_record(-1);
         if (count == records) begin
            // dropped bytes after the last counted record
            repeat ($urandom_range(0, 4)) begin
               cd_stream.push_back(8'($urandom));
               stim_bytes++;
            end
         end else if ($urandom_range(2) == 0) begin
            random_record($urandom_range(1, 60));
         end
         wait_idle();
      end

      // no idling from here on, records back to back
      quiet = 1'b1;
      write_entry_count(64'd3);
      repeat (3) random_record(-1);
      wait_idle();

      // bad signature byte halts the parser for good
      write_entry_count(64'd2);
      x = $urandom_range(0, SIG_BYTES - 1);
      for (int i = 0; i < x; i++) cd_stream.push_back(CD_SIGNATURE[8*i +: 8]);
      wrong = CD_SIGNATURE[8*x +: 8] ^ 8'($urandom_range(1, 255));
      cd_stream.push_back(wrong);
      random_record(-1);
      wait_idle();
      // a new count does not lift the halt
      write_entry_count(64'd5);
      random_record(-1);
      wait_idle();

      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
